/* hdl/pwat_pkg.sv */
// Package for the pointer-to-word associative table.
// Holds field widths, operation codes, stream packing and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package pwat_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int OP_W = 2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 16;
  localparam int CNT_OUT_W = 7;

  localparam int IN_TDATA_W = 56;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W = OUT_TDATA_W - (1 + VAL_W + 1 + CNT_OUT_W);

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

/* hdl/pwat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the key and value store of the associative table. No dependencies.
`timescale 1ns / 1ps

module pwat_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/pointer_to_word_assoc_table_top.sv */
// Top level of the pointer-to-word associative table: sequencer, scan compare and output register.
// Depends on pwat_pkg and pwat_ram.
`timescale 1ns / 1ps

// The table maps 32-bit keys to 16-bit values and holds up to TABLE_ENTRIES entries in
// one RAM. Each input transfer carries a lookup, a set or a clear and yields exactly one
// result transfer. A lookup or set scans the stored entries in order, one key compare per
// cycle through the single RAM read port, ending early on a hit. A clear or an unused
// operation code skips the scan and goes straight to its result. The
// block takes one item at a time; the result waits in an output register while the next
// item is accepted. A set of a new key while the table is full changes nothing and sets
// table_full in its result.
module pointer_to_word_assoc_table_top
  import pwat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: operation[1:0], key[33:2], new_value[49:34], zero fill.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: found[0], read_value[16:1], table_full[17], entry_count[24:18].
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = KEY_W + VAL_W;
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(TABLE_ENTRIES);

  state_t state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic res_found_r, res_found_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic res_full_r, res_full_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic hit;
  logic in_xfer;

  pwat_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(idx_r[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign rd_key = rd_data[KEY_W-1:0];
  assign rd_val = rd_data[ENT_W-1:KEY_W];
  assign hit = pend_r && (rd_key == key_r);

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_tdata[OP_W-1:0];
      key_r <= in_tdata[OP_W+KEY_W-1:OP_W];
      val_r <= in_tdata[OP_W+KEY_W+VAL_W-1:OP_W+KEY_W];
    end
    idx_r <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_found_r <= res_found_nxt;
    res_val_r <= res_val_nxt;
    res_full_r <= res_full_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    pend_nxt = 1'b0;
    pend_idx_nxt = idx_r[IDX_W-1:0];
    res_found_nxt = res_found_r;
    res_val_nxt = res_val_r;
    res_full_nxt = res_full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    wr_en = 1'b0;
    wr_addr = pend_idx_r;
    wr_data = {val_r, key_r};

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          res_found_nxt = 1'b0;
          res_val_nxt = '0;
          res_full_nxt = 1'b0;
          idx_nxt = '0;
          case (in_tdata[OP_W-1:0])
            OP_LOOKUP, OP_SET: begin
              state_nxt = ST_SCAN;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          if (op_r == OP_LOOKUP) begin
            res_val_nxt = rd_val;
          end else begin
            wr_en = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (idx_r >= count_r) begin
          if (op_r == OP_SET) begin
            if (count_r >= CAPACITY) begin
              res_full_nxt = 1'b1;
            end else begin
              wr_en = 1'b1;
              wr_addr = count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_W'(1);
            end
          end
          state_nxt = ST_DONE;
        end else begin
          pend_nxt = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {{OUT_PAD_W{1'b0}}, CNT_OUT_W'(count_r), res_full_r,
                          res_val_r, res_found_r};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/pwat_checker.sv */
// Port-level checker for the pointer-to-word associative table, bound to the top level.
// Depends on pwat_pkg and pointer_to_word_assoc_table_top.
`timescale 1ns / 1ps

module pwat_checker
  import pwat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic [CNT_OUT_W-1:0] CAP_OUT = CNT_OUT_W'(TABLE_ENTRIES);
  localparam bit COUNT_WRAPS = (TABLE_ENTRIES > 127);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while an operation was in progress.");

  a_found_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[17]))
    else $error("Result reports both a match and a full table.");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == '0)
    else $error("Nonzero value without a match.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> COUNT_WRAPS || (out_tdata[24:18] <= CAP_OUT))
    else $error("Entry count exceeds the table capacity.");

endmodule

bind pointer_to_word_assoc_table_top pwat_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_pwat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* verif/pointer_to_word_assoc_table_top_tb.sv */
// Self-checking testbench for pointer_to_word_assoc_table_top.
// It uses a directed stimulus table followed by random sequences; each result transfer is
// checked against its typed row or the predictor. Depends on pwat_pkg and the RTL of the block.
`timescale 1ns / 1ps

module pointer_to_word_assoc_table_top_tb;
  import pwat_pkg::*;

  localparam int                N_ENTRIES     = TABLE_ENTRIES_DEF;
  localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;
  localparam int                RANDOM_ITEMS  = 950;
  localparam int                DRAIN_CYCLES  = N_ENTRIES + 20;
  localparam int                CYCLE_LIMIT   = 1000000;
  localparam int                HOLD_START    = 4000;
  localparam int                HOLD_CYCLES   = 400;

  typedef struct packed {
    logic                 found;
    logic [VAL_W-1:0]     read_value;
    logic                 table_full;
    logic [CNT_OUT_W-1:0] entry_count;
  } assoc_result_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               typed;
    assoc_result_t    result;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [KEY_W-1:0] tbl_keys [N_ENTRIES];
  logic [VAL_W-1:0] tbl_vals [N_ENTRIES];
  int               tbl_count;

  assoc_result_t pending_results [$];
  stim_row_t     directed_rows [20];

  int          err_cnt;
  int          cycle_cnt;
  int          burst_left;
  int unsigned n_items, n_hits, n_misses, n_inserts, n_updates, n_refused, n_clears, n_unused;

  pointer_to_word_assoc_table_top #(
    .TABLE_ENTRIES(N_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[pointer_to_word_assoc_table_top] ERROR");
      $finish;
    end
  end

  function automatic assoc_result_t table_apply(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] value);
    assoc_result_t res;
    int            slot;
    res  = '0;
    slot = -1;
    if (op == OP_LOOKUP || op == OP_SET) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_keys[i] == key) begin
          slot = i;
          break;
        end
      end
    end
    case (op)
      OP_LOOKUP: begin
        if (slot >= 0) begin
          res.found      = 1'b1;
          res.read_value = tbl_vals[slot];
          n_hits++;
        end else begin
          n_misses++;
        end
      end
      OP_SET: begin
        if (slot >= 0) begin
          res.found      = 1'b1;
          tbl_vals[slot] = value;
          n_updates++;
        end else if (tbl_count >= N_ENTRIES) begin
          res.table_full = 1'b1;
          n_refused++;
        end else begin
          tbl_keys[tbl_count] = key;
          tbl_vals[tbl_count] = value;
          tbl_count++;
          n_inserts++;
        end
      end
      OP_CLEAR: begin
        tbl_count = 0;
        n_clears++;
      end
      default: begin
        n_unused++;
      end
    endcase
    res.entry_count = tbl_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value, input bit typed,
                         input assoc_result_t typed_result);
    assoc_result_t predicted;
    int            gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - OP_W - KEY_W - VAL_W){1'b0}}, value, key, op};
    predicted = table_apply(op, key, value);
    pending_results.push_back(typed ? typed_result : predicted);
    n_items++;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (tbl_count > 0 && r < 55) return tbl_keys[$urandom_range(0, tbl_count - 1)];
    if (r < 70) return KEY_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  task automatic run_mixed(input int len);
    int               r;
    logic [OP_W-1:0]  op;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_LOOKUP;
      else if (r < 95) op = OP_SET;
      else if (r < 97) op = OP_CLEAR;
      else op = OP_UNUSED;
      send_op(op, pick_key(), VAL_W'($urandom), 1'b0, '0);
    end
  endtask

  // Fills the table to capacity, then pushes on with refused inserts, updates and lookups.
  task automatic run_fill(output int sent);
    sent = 0;
    while (tbl_count < N_ENTRIES) begin
      if ($urandom_range(0, 3) == 0) send_op(OP_LOOKUP, pick_key(), VAL_W'($urandom), 1'b0, '0);
      else send_op(OP_SET, $urandom, VAL_W'($urandom), 1'b0, '0);
      sent++;
    end
    for (int i = 0; i < 8; i++) begin
      case (i % 3)
        0:       send_op(OP_SET, $urandom, VAL_W'($urandom), 1'b0, '0);
        1:       send_op(OP_SET, pick_key(), VAL_W'($urandom), 1'b0, '0);
        default: send_op(OP_LOOKUP, pick_key(), VAL_W'($urandom), 1'b0, '0);
      endcase
      sent++;
    end
  endtask

  initial begin
    int rx_cycles;
    int mode;
    int seg;
    bit held;
    out_tready = 1'b0;
    rx_cycles  = 0;
    held       = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 200);
      for (int i = 0; i < seg; i++) begin
        @(negedge clk);
        rx_cycles++;
        if (!held && rx_cycles >= HOLD_START) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          rx_cycles += HOLD_CYCLES - 1;
          held = 1'b1;
        end else begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 3) != 0);
            2:       out_tready <= ($urandom_range(0, 1) == 1);
            default: out_tready <= ($urandom_range(0, 5) == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    assoc_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result: tdata=%h", out_tdata);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[0] !== exp_res.found) begin
          $error("found: expected %0d, actual %0d", exp_res.found, out_tdata[0]);
          err_cnt++;
        end
        if (out_tdata[16:1] !== exp_res.read_value) begin
          $error("read_value: expected %h, actual %h", exp_res.read_value, out_tdata[16:1]);
          err_cnt++;
        end
        if (out_tdata[17] !== exp_res.table_full) begin
          $error("table_full: expected %0d, actual %0d", exp_res.table_full, out_tdata[17]);
          err_cnt++;
        end
        if (out_tdata[24:18] !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_res.entry_count,
                 out_tdata[24:18]);
          err_cnt++;
        end
        if (out_tdata[OUT_TDATA_W-1:25] !== '0) begin
          $error("zero fill: expected 0, actual %h", out_tdata[OUT_TDATA_W-1:25]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int random_sent;
    int fill_sent;
    int seg_idx;
    int seg;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    burst_left  = 0;
    tbl_count   = 0;
    random_sent = 0;
    seg_idx     = 0;
    seg         = 0;
    {n_items, n_hits, n_misses, n_inserts, n_updates, n_refused, n_clears, n_unused} = '0;

    directed_rows = '{
      '{OP_LOOKUP, 32'h0000_0000, 16'h0000, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd0}},
      '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd0}},
      '{OP_CLEAR,  32'h0000_0000, 16'h0000, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd0}},
      '{OP_SET,    32'h0000_0000, 16'h0000, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd1}},
      '{OP_SET,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd2}},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b1, {1'b1, 16'hFFFF, 1'b0, 7'd2}},
      '{OP_LOOKUP, 32'h0000_0000, 16'hFFFF, 1'b1, {1'b1, 16'h0000, 1'b0, 7'd2}},
      '{OP_SET,    32'h0000_0000, 16'hFFFF, 1'b1, {1'b1, 16'h0000, 1'b0, 7'd2}},
      '{OP_LOOKUP, 32'h0000_0000, 16'h0000, 1'b1, {1'b1, 16'hFFFF, 1'b0, 7'd2}},
      '{OP_SET,    32'h1234_5678, 16'hA5A5, 1'b0, '0},
      '{OP_SET,    32'h8000_0001, 16'h5A5A, 1'b0, '0},
      '{OP_LOOKUP, 32'h1234_5678, 16'h0000, 1'b0, '0},
      '{OP_LOOKUP, 32'h1234_5679, 16'h0000, 1'b0, '0},
      '{OP_UNUSED, 32'h1234_5678, 16'h1111, 1'b0, '0},
      '{OP_SET,    32'hFFFF_FFFF, 16'h0001, 1'b0, '0},
      '{OP_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1'b0, '0},
      '{OP_CLEAR,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd0}},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd0}},
      '{OP_LOOKUP, 32'h0000_0000, 16'h0000, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd0}},
      '{OP_SET,    32'h0000_FFFF, 16'h8000, 1'b1, {1'b0, 16'h0000, 1'b0, 7'd1}}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
              directed_rows[i].typed, directed_rows[i].result);
    end

    while (random_sent < RANDOM_ITEMS) begin
      if (seg_idx == 0 || $urandom_range(0, 99) < 15) begin
        run_fill(fill_sent);
        random_sent += fill_sent;
      end else begin
        seg = $urandom_range(10, 60);
        run_mixed(seg);
        random_sent += seg;
      end
      seg_idx++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_cnt++;
    end

    $display("Ran %0d transfers: %0d lookup hits, %0d misses, %0d inserts, %0d updates,",
             n_items, n_hits, n_misses, n_inserts, n_updates);
    $display("%0d sets refused on a full table, %0d clears, %0d unused codes, %0d mismatches.",
             n_refused, n_clears, n_unused, err_cnt);
    if (err_cnt == 0) begin
      $display("[pointer_to_word_assoc_table_top] OK");
    end else begin
      $display("[pointer_to_word_assoc_table_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pwat_pkg.sv
hdl/pwat_ram.sv
hdl/pointer_to_word_assoc_table_top.sv
hdl/pwat_checker.sv
verif/pointer_to_word_assoc_table_top_tb.sv
